// ===== rtl/lssp_pkg.sv =====
package lssp_pkg;

  // Widths shared by the series stages
  localparam int TERM_W = 33;
  localparam int OPND_W = 31;
  localparam int ACC_W  = 34;
  localparam int FRAC   = 30;

  // Series lengths
  localparam int COS_TERMS = 10;
  localparam int SIN_TERMS = 10;
  localparam int EXP_TERMS = 12;

  // Register reset values
  localparam logic [19:0] GROWTH_RESET = 20'd65536;
  localparam logic [23:0] HEIGHT_RESET = 24'd65536;

  // Fixed-point constants
  localparam logic [24:0] LOG2E_Q24   = 25'd24204407;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075408;
  // 21 full turns, makes any u*2^16 nonnegative
  localparam logic [40:0] TURN_OFFSET = 41'd566707583568;
  localparam logic [TERM_W-1:0] Q30_ONE = 33'd1073741824;

  typedef enum logic [0:0] {
    REG_GROWTH = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [23:0] angle_u;
    logic        [16:0] height_v;
  } item_t;

  typedef struct packed {
    logic signed [47:0] x_out;
    logic signed [23:0] y_out;
    logic signed [47:0] z_out;
    logic               overflow;
  } result_t;

endpackage

// ===== rtl/lssp_delay.sv =====
module lssp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [DEPTH];

  // Advance the line with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  assign q = pipe[DEPTH-1];

endmodule

// ===== rtl/lssp_series_term.sv =====
module lssp_series_term
  import lssp_pkg::*;
#(
  parameter int DIV  = 1,
  parameter bit NEG  = 1'b0,
  parameter int NMUL = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [TERM_W-1:0]        term_in,
  input  logic [OPND_W-1:0]        opnd_in,
  input  logic signed [ACC_W-1:0]  acc_in,
  output logic [TERM_W-1:0]        term_out,
  output logic [OPND_W-1:0]        opnd_out,
  output logic signed [ACC_W-1:0]  acc_out
);

  localparam int PW = TERM_W + OPND_W;
  localparam int RW = TERM_W + 1;
  localparam int QW = TERM_W + RW;
  localparam int BW = 2 * TERM_W;
  localparam logic [RW-1:0]     RECIP   = RW'((64'd1 << TERM_W) / DIV);
  localparam logic [TERM_W-1:0] DIVISOR = TERM_W'(DIV);

  logic [TERM_W-1:0]       mul_a   [NMUL];
  logic [TERM_W-1:0]       mul_q   [NMUL];
  logic [OPND_W-1:0]       op_a    [NMUL];
  logic [OPND_W-1:0]       op_q    [NMUL];
  logic signed [ACC_W-1:0] acc_a   [NMUL];
  logic signed [ACC_W-1:0] acc_q   [NMUL];
  logic [PW-1:0]           full    [NMUL];

  logic [QW-1:0]           recip_full;
  logic [TERM_W-1:0]       div_p;
  logic [TERM_W-1:0]       div_q0;
  logic [OPND_W-1:0]       div_op;
  logic signed [ACC_W-1:0] div_acc;
  logic [BW-1:0]           back_full;
  logic [TERM_W-1:0]       rem;
  logic [TERM_W-1:0]       quo;

  // Chain the multiply stages: term = term * x >> 30
  always_comb begin
    mul_a[0] = term_in;
    op_a[0]  = opnd_in;
    acc_a[0] = acc_in;
    for (int k = 1; k < NMUL; k++) begin
      mul_a[k] = mul_q[k-1];
      op_a[k]  = op_q[k-1];
      acc_a[k] = acc_q[k-1];
    end
    for (int k = 0; k < NMUL; k++) begin
      full[k] = PW'(mul_a[k]) * PW'(op_a[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NMUL; k++) begin
        mul_q[k] <= full[k][FRAC +: TERM_W];
        op_q[k]  <= op_a[k];
        acc_q[k] <= acc_a[k];
      end
    end
  end

  // Estimate the quotient by reciprocal, low by at most one
  assign recip_full = QW'(mul_q[NMUL-1]) * QW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      div_p   <= mul_q[NMUL-1];
      div_q0  <= recip_full[TERM_W +: TERM_W];
      div_op  <= op_q[NMUL-1];
      div_acc <= acc_q[NMUL-1];
    end
  end

  // Correct the quotient and fold the term into the sum
  assign back_full = BW'(div_q0) * BW'(DIVISOR);
  assign rem       = div_p - back_full[TERM_W-1:0];
  assign quo       = div_q0 + TERM_W'(rem >= DIVISOR);

  always_ff @(posedge clk) begin
    if (en) begin
      term_out <= quo;
      opnd_out <= div_op;
      if (NEG) begin
        acc_out <= div_acc - $signed({1'b0, quo});
      end else begin
        acc_out <= div_acc + $signed({1'b0, quo});
      end
    end
  end

endmodule

// ===== rtl/log_spiral_surface_point.sv =====
// Logarithmic spiral surface point. Each beat on the item channel carries
// (u, v) and yields one result beat with x = e^(a*u)*cos(u), y = H*v and
// z = e^(a*u)*sin(u) in Q.16, saturated, with overflow set when any
// coordinate was clipped. The growth rate a and height scale H are written
// through the configuration port; the user must write them only while no item is
// in flight, and the block itself does not enforce this. The block is a 48-stage
// pipeline that takes a new item every cycle; its length is set by the sine and
// cosine Taylor series, ten terms of four stages each. A stall on the result
// channel holds the whole pipeline, so the item channel stalls in the same cycle.
module log_spiral_surface_point
  import lssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int TRIG_LAT = COS_TERMS * 4;
  localparam int EXP_LAT  = EXP_TERMS * 3;
  localparam int ST_SER   = 5;
  localparam int ST_JOIN  = ST_SER + TRIG_LAT;
  localparam int ST_OUT   = ST_JOIN + 3;
  localparam int EXP_DLY  = TRIG_LAT - EXP_LAT;
  localparam int BUN_W    = 35;

  function automatic logic [48:0] scale_out(input logic [62:0] p, input logic neg,
                                            input logic signed [7:0] exp_i);
    logic signed [8:0] s;
    logic [47:0]       lim;
    logic [47:0]       res;
    logic              ovf;
    logic [7:0]        n;
    logic [63:0]       rnd;
    s   = $signed({exp_i[7], exp_i}) - 9'sd44;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    ovf = 1'b0;
    res = '0;
    n   = '0;
    rnd = '0;
    if (!s[8]) begin
      if (p == '0) begin
        res = '0;
      end else if (s >= 9'sd47 || p > (63'(lim) >> s[5:0])) begin
        res = lim;
        ovf = 1'b1;
      end else begin
        res = 48'(p << s[5:0]);
      end
    end else begin
      n = 8'(-s);
      if (n >= 8'd63) begin
        res = '0;
      end else begin
        rnd = ({1'b0, p} + (64'd1 << (n - 8'd1))) >> n;
        if (rnd > 64'(lim)) begin
          res = lim;
          ovf = 1'b1;
        end else begin
          res = rnd[47:0];
        end
      end
    end
    if (neg) begin
      res = -res;
    end
    return {ovf, res};
  endfunction

  function automatic logic [30:0] clamp_unit(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1]) begin
      return '0;
    end else if ($unsigned(v) > ACC_W'(Q30_ONE)) begin
      return 31'(Q30_ONE);
    end
    return v[30:0];
  endfunction

  logic [19:0] growth_rate;
  logic [23:0] height_scale;
  logic        adv;
  logic [ST_OUT:1] vld;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      growth_rate  <= GROWTH_RESET;
      height_scale <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GROWTH: growth_rate  <= cfg_data[19:0];
        REG_HEIGHT: height_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance every stage unless the output beat is held
  assign adv          = !(result_valid && result_stall);
  assign item_stall   = !adv;
  assign result_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_OUT-1:1], item_valid};
    end
  end

  // Stage 1: a*u, shifted angle, H*v
  logic signed [43:0] t_d, t1;
  logic [40:0]        turn_d, turn1;
  logic signed [41:0] hv_d, hv1;

  assign t_d    = $signed(growth_rate) * $signed(item.angle_u);
  assign turn_d = {item.angle_u[23], item.angle_u, 16'd0} + TURN_OFFSET;
  assign hv_d   = $signed(height_scale) * $signed({1'b0, item.height_v});

  always_ff @(posedge clk) begin
    if (adv) begin
      t1    <= t_d;
      turn1 <= turn_d;
      hv1   <= hv_d;
    end
  end

  // Stage 2: clamp and take |t|, reduce turns, round and saturate y
  logic [43:0] t_abs;
  logic [38:0] tm_d, tm2;
  logic        tneg2;
  logic [40:0] turn2_d, turn2;
  logic        yneg;
  logic [41:0] ym_abs;
  logic [42:0] ym_sum;
  logic [26:0] yr, ylim;
  logic [23:0] y_d, y2;
  logic        ovfy_d, ovfy2;

  assign t_abs = t1[43] ? 44'(-t1) : 44'(t1);
  assign tm_d  = (t_abs > 44'd274877906944) ? 39'd274877906944 : t_abs[38:0];

  always_comb begin
    turn2_d = turn1;
    for (int k = 5; k >= 4; k--) begin
      if (turn2_d >= (41'(TWO_PI_Q32) << k)) begin
        turn2_d = turn2_d - (41'(TWO_PI_Q32) << k);
      end
    end
  end

  always_comb begin
    yneg   = hv1[41];
    ym_abs = yneg ? 42'(-hv1) : 42'(hv1);
    ym_sum = 43'(ym_abs) + 43'd32768;
    yr     = ym_sum[42:16];
    ylim   = yneg ? 27'd8388608 : 27'd8388607;
    ovfy_d = 1'b0;
    if (yr > ylim) begin
      yr     = ylim;
      ovfy_d = 1'b1;
    end
    y_d = yneg ? 24'(-yr[23:0]) : yr[23:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm2   <= tm_d;
      tneg2 <= t1[43];
      turn2 <= turn2_d;
      y2    <= y_d;
      ovfy2 <= ovfy_d;
    end
  end

  // Stage 3: |t| * log2(e), reduce turns
  logic [63:0] w_d, w3;
  logic        tneg3;
  logic [40:0] turn3_d, turn3;
  logic [23:0] y3;
  logic        ovfy3;

  assign w_d = 64'(tm2) * 64'(LOG2E_Q24);

  always_comb begin
    turn3_d = turn2;
    for (int k = 3; k >= 2; k--) begin
      if (turn3_d >= (41'(TWO_PI_Q32) << k)) begin
        turn3_d = turn3_d - (41'(TWO_PI_Q32) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w3    <= w_d;
      tneg3 <= tneg2;
      turn3 <= turn3_d;
      y3    <= y2;
      ovfy3 <= ovfy2;
    end
  end

  // Stage 4: split into integer exponent and fraction, finish turn reduction
  logic [7:0]        ip;
  logic [55:0]       fr, f_d;
  logic signed [7:0] i_d, i4;
  logic [29:0]       f4;
  logic [40:0]       turn4_d;
  logic [34:0]       r4;
  logic [23:0]       y4;
  logic              ovfy4;

  assign ip = w3[63:56];
  assign fr = w3[55:0];

  always_comb begin
    if (!tneg3) begin
      i_d = $signed(ip);
      f_d = fr;
    end else if (fr != '0) begin
      i_d = $signed(-ip - 8'd1);
      f_d = 56'd0 - fr;
    end else begin
      i_d = $signed(-ip);
      f_d = '0;
    end
  end

  always_comb begin
    turn4_d = turn3;
    for (int k = 1; k >= 0; k--) begin
      if (turn4_d >= (41'(TWO_PI_Q32) << k)) begin
        turn4_d = turn4_d - (41'(TWO_PI_Q32) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i4    <= i_d;
      f4    <= f_d[55:26];
      r4    <= turn4_d[34:0];
      y4    <= y3;
      ovfy4 <= ovfy3;
    end
  end

  // Stage 5: series argument f*ln2, quadrant and remainder
  logic [59:0]       ye_full;
  logic [29:0]       yexp5;
  logic [34:0]       rq;
  logic [1:0]        quad_d;
  logic [30:0]       x5;
  logic [1:0]        quad5;
  logic signed [7:0] i5;
  logic [23:0]       y5;
  logic              ovfy5;

  assign ye_full = 60'(f4) * 60'(LN2_Q30);

  always_comb begin
    rq     = r4;
    quad_d = 2'b00;
    if (rq >= (35'(HALF_PI_Q32) << 1)) begin
      rq        = rq - (35'(HALF_PI_Q32) << 1);
      quad_d[1] = 1'b1;
    end
    if (rq >= 35'(HALF_PI_Q32)) begin
      rq        = rq - 35'(HALF_PI_Q32);
      quad_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yexp5 <= ye_full[59:30];
      x5    <= rq[32:2];
      quad5 <= quad_d;
      i5    <= i4;
      y5    <= y4;
      ovfy5 <= ovfy4;
    end
  end

  // Series chains
  wire [TERM_W-1:0]        cos_term [COS_TERMS+1];
  wire [OPND_W-1:0]        cos_op   [COS_TERMS+1];
  wire signed [ACC_W-1:0]  cos_acc  [COS_TERMS+1];
  wire [TERM_W-1:0]        sin_term [SIN_TERMS+1];
  wire [OPND_W-1:0]        sin_op   [SIN_TERMS+1];
  wire signed [ACC_W-1:0]  sin_acc  [SIN_TERMS+1];
  wire [TERM_W-1:0]        exp_term [EXP_TERMS+1];
  wire [OPND_W-1:0]        exp_op   [EXP_TERMS+1];
  wire signed [ACC_W-1:0]  exp_acc  [EXP_TERMS+1];

  assign cos_term[0] = Q30_ONE;
  assign cos_op[0]   = x5;
  assign cos_acc[0]  = $signed(ACC_W'(Q30_ONE));
  assign sin_term[0] = TERM_W'(x5);
  assign sin_op[0]   = x5;
  assign sin_acc[0]  = $signed(ACC_W'(x5));
  assign exp_term[0] = Q30_ONE;
  assign exp_op[0]   = {1'b0, yexp5};
  assign exp_acc[0]  = $signed(ACC_W'(Q30_ONE));

  for (genvar g = 0; g < COS_TERMS; g++) begin : g_cos
    lssp_series_term #(
      .DIV  ((2*g+1)*(2*g+2)),
      .NEG  ((g % 2) == 0),
      .NMUL (2)
    ) u_term (
      .clk      (clk),
      .en       (adv),
      .term_in  (cos_term[g]),
      .opnd_in  (cos_op[g]),
      .acc_in   (cos_acc[g]),
      .term_out (cos_term[g+1]),
      .opnd_out (cos_op[g+1]),
      .acc_out  (cos_acc[g+1])
    );
  end

  for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
    lssp_series_term #(
      .DIV  ((2*g+2)*(2*g+3)),
      .NEG  ((g % 2) == 0),
      .NMUL (2)
    ) u_term (
      .clk      (clk),
      .en       (adv),
      .term_in  (sin_term[g]),
      .opnd_in  (sin_op[g]),
      .acc_in   (sin_acc[g]),
      .term_out (sin_term[g+1]),
      .opnd_out (sin_op[g+1]),
      .acc_out  (sin_acc[g+1])
    );
  end

  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_exp
    lssp_series_term #(
      .DIV  (g+1),
      .NEG  (1'b0),
      .NMUL (1)
    ) u_term (
      .clk      (clk),
      .en       (adv),
      .term_in  (exp_term[g]),
      .opnd_in  (exp_op[g]),
      .acc_in   (exp_acc[g]),
      .term_out (exp_term[g+1]),
      .opnd_out (exp_op[g+1]),
      .acc_out  (exp_acc[g+1])
    );
  end

  // Align mantissa and side data with the trig results
  logic [31:0]      m_join;
  logic [BUN_W-1:0] bun_join;

  lssp_delay #(.W(32), .DEPTH(EXP_DLY)) u_m_dly (
    .clk (clk),
    .en  (adv),
    .d   (exp_acc[EXP_TERMS][31:0]),
    .q   (m_join)
  );

  lssp_delay #(.W(BUN_W), .DEPTH(TRIG_LAT)) u_side_dly (
    .clk (clk),
    .en  (adv),
    .d   ({i5, quad5, y5, ovfy5}),
    .q   (bun_join)
  );

  // Stage 46: clamp cos and sin, place them in the quadrant
  logic [30:0]        cc, ss;
  logic signed [31:0] co_d, si_d, co46, si46;
  logic [31:0]        m46;
  logic signed [7:0]  i46;
  logic [23:0]        y46;
  logic               ovfy46;

  always_comb begin
    cc = clamp_unit(cos_acc[COS_TERMS]);
    ss = clamp_unit(sin_acc[SIN_TERMS]);
    case (quad_t'(bun_join[26:25]))
      QUAD_0: begin
        co_d = $signed({1'b0, cc});
        si_d = $signed({1'b0, ss});
      end
      QUAD_1: begin
        co_d = -$signed({1'b0, ss});
        si_d = $signed({1'b0, cc});
      end
      QUAD_2: begin
        co_d = -$signed({1'b0, cc});
        si_d = -$signed({1'b0, ss});
      end
      default: begin
        co_d = $signed({1'b0, ss});
        si_d = -$signed({1'b0, cc});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      co46   <= co_d;
      si46   <= si_d;
      m46    <= m_join;
      i46    <= $signed(bun_join[34:27]);
      y46    <= bun_join[24:1];
      ovfy46 <= bun_join[0];
    end
  end

  // Stage 47: mantissa times |trig|
  logic [30:0]       magx, magz;
  logic [62:0]       px47, pz47;
  logic              negx47, negz47;
  logic signed [7:0] i47;
  logic [23:0]       y47;
  logic              ovfy47;

  assign magx = co46[31] ? 31'(-co46) : co46[30:0];
  assign magz = si46[31] ? 31'(-si46) : si46[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      px47   <= 63'(m46) * 63'(magx);
      pz47   <= 63'(m46) * 63'(magz);
      negx47 <= co46[31];
      negz47 <= si46[31];
      i47    <= i46;
      y47    <= y46;
      ovfy47 <= ovfy46;
    end
  end

  // Stage 48: scale by 2^(i-44), saturate, drive the result beat
  logic [48:0] xs, zs;

  assign xs = scale_out(px47, negx47, i47);
  assign zs = scale_out(pz47, negz47, i47);

  always_ff @(posedge clk) begin
    if (adv) begin
      result.x_out    <= $signed(xs[47:0]);
      result.y_out    <= $signed(y47);
      result.z_out    <= $signed(zs[47:0]);
      result.overflow <= ovfy47 | xs[48] | zs[48];
    end
  end

`ifndef ASSERT_OFF
  a_cfg_growth: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == REG_GROWTH |=> growth_rate == $past(cfg_data[19:0]))
    else $error("growth_rate write lost");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (i4 >= -8'sd93 && i4 <= 8'sd92))
    else $error("exponent out of range");

  a_angle_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_SER] |-> 33'(x5) <= (HALF_PI_Q32 >> 2))
    else $error("reduced angle above a quarter turn");

  a_mantissa: assert property (@(posedge clk) disable iff (rst)
    vld[ST_JOIN] |-> (m_join >= 32'h4000_0000 && m_join < 32'h8000_0000))
    else $error("mantissa outside [1,2)");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    vld[ST_JOIN] |-> (cos_term[COS_TERMS] == '0 && sin_term[SIN_TERMS] == '0 &&
                      cos_op[COS_TERMS] == sin_op[SIN_TERMS]))
    else $error("trig series tail not negligible");

  a_exp_tail: assert property (@(posedge clk) disable iff (rst)
    vld[ST_SER + EXP_LAT] |-> (exp_term[EXP_TERMS] == '0 &&
                               exp_op[EXP_TERMS] < 31'(LN2_Q30)))
    else $error("exp series tail not negligible");
`endif

endmodule

// ===== sim/log_spiral_surface_point_tb.sv =====
module log_spiral_surface_point_tb;
  import lssp_pkg::*;

  localparam int PIPE_DEPTH = 48;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLDOFF_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  log_spiral_surface_point dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the two registers
  logic [19:0] growth_q;
  logic [23:0] height_q;

  item_t   pending_items[$];
  result_t expected_points[$];
  int      mismatches = 0;
  int      send_idle_pct;
  int      stall_pct;
  int      holdoff_left;
  bit      holdoff_req;
  bit      holdoff_done;
  longint  cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // 2^f, f in Q.30
  function automatic longint unsigned exp2_q30(longint unsigned f30);
    longint unsigned y, sum, term;
    y = (f30 * 64'd744261118) >> 30;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = (term * y) >> 30;
      term = term / k;
      sum += term;
    end
    return sum;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v < 0) return 0;
    if (v > (64'sd1 << 30)) return 64'sd1 << 30;
    return v;
  endfunction

  function automatic void angle_trig(longint u16, output longint co, output longint si);
    longint half_pi, two_pi, r, q, x, c, s;
    longint unsigned t;
    quad_t quad;
    half_pi = 64'sd6746518852;
    two_pi = 4 * half_pi;
    r = (u16 * 65536) % two_pi;
    if (r < 0) r += two_pi;
    q = r / half_pi;
    x = (r - q * half_pi) >>> 2;
    c = 64'sd1 << 30;
    t = 64'd1 << 30;
    for (int n = 2; n <= 20; n += 2) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((n - 1) * n);
      c += (n % 4 == 2) ? -longint'(t) : longint'(t);
    end
    s = x;
    t = x;
    for (int n = 3; n <= 21; n += 2) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((n - 1) * n);
      s += (n % 4 == 3) ? -longint'(t) : longint'(t);
    end
    c = clamp_q30(c);
    s = clamp_q30(s);
    quad = quad_t'(q[1:0]);
    case (quad)
      QUAD_0: begin co = c; si = s; end
      QUAD_1: begin co = -s; si = c; end
      QUAD_2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  // Scale m*|trig|*2^(i-44) into Q.16, saturating to 48 bits
  function automatic longint scale_coord(longint unsigned m, longint trig, int i,
                                         inout bit ovf);
    bit neg;
    longint unsigned mag, p, lim, res;
    int s, n;
    neg = trig < 0;
    mag = neg ? -trig : trig;
    p = m * mag;
    lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
    s = i - 44;
    if (s >= 0) begin
      if (p == 0) res = 0;
      else if (s >= 47 || p > (lim >> s)) begin
        res = lim;
        ovf = 1'b1;
      end else res = p << s;
    end else begin
      n = -s;
      if (n >= 63) res = 0;
      else begin
        res = (p + (64'd1 << (n - 1))) >> n;
        if (res > lim) begin
          res = lim;
          ovf = 1'b1;
        end
      end
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic result_t spiral_point(item_t it);
    result_t r;
    longint a, h, u, t, co, si, hv, tlim;
    longint unsigned tm, w, ip, fr, f, m, ym, ylim;
    int i;
    bit ovf, tneg, yneg;
    a = longint'($signed(growth_q));
    h = longint'($signed(height_q));
    u = longint'(it.angle_u);
    ovf = 1'b0;
    tlim = 64'sd64 <<< 32;
    t = a * u;
    if (t > tlim) t = tlim;
    if (t < -tlim) t = -tlim;
    tneg = t < 0;
    tm = tneg ? -t : t;
    w = tm * 64'd24204407;
    ip = w >> 56;
    fr = w & ((64'd1 << 56) - 1);
    if (!tneg) begin
      i = int'(ip);
      f = fr;
    end else if (fr != 0) begin
      i = -int'(ip) - 1;
      f = (64'd1 << 56) - fr;
    end else begin
      i = -int'(ip);
      f = 0;
    end
    m = exp2_q30(f >> 26);
    angle_trig(u, co, si);
    r.x_out = 48'(scale_coord(m, co, i, ovf));
    r.z_out = 48'(scale_coord(m, si, i, ovf));
    hv = h * longint'({1'b0, it.height_v});
    yneg = hv < 0;
    ym = yneg ? -hv : hv;
    ym = (ym + 32768) >> 16;
    ylim = yneg ? (64'd1 << 23) : (64'd1 << 23) - 1;
    if (ym > ylim) begin
      ym = ylim;
      ovf = 1'b1;
    end
    r.y_out = 24'(yneg ? -longint'(ym) : longint'(ym));
    r.overflow = ovf;
    return r;
  endfunction

  // Driver: offer queued beats, hold a stalled beat
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_points.push_back(spiral_point(item));
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_req && !holdoff_done) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      result_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result);
      end else begin
        want = expected_points.pop_front();
        if (want !== result) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected x=%0d y=%0d z=%0d ovf=%0b, ",
                      "got x=%0d y=%0d z=%0d ovf=%0b"},
                     want.x_out, want.y_out, want.z_out, want.overflow,
                     result.x_out, result.y_out, result.z_out, result.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.angle_u = 24'($urandom());
    case ($urandom_range(3))
      0: it.angle_u = $signed(24'($urandom_range(1638400))) - 24'sd819200;
      1: it.angle_u = $signed(24'($urandom_range(65536))) - 24'sd32768;
      default: ;
    endcase
    it.height_v = ($urandom_range(3) == 0) ? 17'($urandom()) : 17'($urandom_range(65536));
    return it;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_GROWTH) growth_q = val[19:0];
    else height_q = val;
  endtask

  task automatic drain_points();
    while (pending_items.size() > 0 || item_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int k = 0; k < n_items; k++) pending_items.push_back(rand_item());
    drain_points();
  endtask

  initial begin
    item_t it;
    logic signed [23:0] corner_u[6];
    logic [16:0] corner_v[4];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_GROWTH;
    cfg_data = '0;
    growth_q = GROWTH_RESET;
    height_q = HEIGHT_RESET;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under reset values
    corner_u = '{24'sh800000, 24'sh7fffff, 24'sd0, 24'sd102944, -24'sd102944, 24'sd411775};
    corner_v = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768};
    foreach (corner_u[k]) begin
      it.angle_u = corner_u[k];
      it.height_v = corner_v[k % 4];
      pending_items.push_back(it);
    end
    drain_points();

    // Extreme register settings with saturating items
    write_reg(REG_GROWTH, 24'h080000);
    write_reg(REG_HEIGHT, 24'h800000);
    foreach (corner_u[k]) begin
      it.angle_u = corner_u[k];
      it.height_v = corner_v[(k + 1) % 4];
      pending_items.push_back(it);
    end
    drain_points();
    write_reg(REG_GROWTH, 24'h07ffff);
    write_reg(REG_HEIGHT, 24'h7fffff);
    foreach (corner_u[k]) begin
      it.angle_u = corner_u[k];
      it.height_v = corner_v[(k + 2) % 4];
      pending_items.push_back(it);
    end
    drain_points();

    // Random phases across settings and idling mixes
    write_reg(REG_GROWTH, 24'd0);
    write_reg(REG_HEIGHT, 24'hff0000);
    run_phase(200, 0, 0);
    write_reg(REG_GROWTH, 24'h0fe000);
    write_reg(REG_HEIGHT, 24'd3000000);
    run_phase(200, 65, 0);
    write_reg(REG_GROWTH, 24'h004000);
    run_phase(200, 0, 65);
    write_reg(REG_GROWTH, 24'($urandom()));
    write_reg(REG_HEIGHT, 24'($urandom()));
    run_phase(200, 25, 25);

    // Long receiver hold-off while the sender keeps offering
    write_reg(REG_GROWTH, GROWTH_RESET);
    write_reg(REG_HEIGHT, HEIGHT_RESET);
    holdoff_req = 1'b1;
    run_phase(200, 0, 0);

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lssp_pkg.sv
rtl/lssp_delay.sv
rtl/lssp_series_term.sv
rtl/log_spiral_surface_point.sv
sim/log_spiral_surface_point_tb.sv
